>>> rtl/sphere_frustum_cull_defines.svh
// ----------------------------------------------------------------------------
// Sphere frustum cull assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SPHERE_FRUSTUM_CULL_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Consequent must hold in the cycle after reset is seen.
`define SFC_ASSERT_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull package
// Widths, configuration layouts, pipeline item types and codes.
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int POS_W      = 20;
   localparam int AXIS_W     = 16;
   localparam int TAG_W      = 16;
   localparam int LIM_W      = 24;
   localparam int MARGIN_W   = 24;
   localparam int TAN_W      = 16;
   localparam int DELTA_W    = POS_W + 1;
   localparam int PROD_W     = DELTA_W + AXIS_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int LIM_SHIFT  = 14;
   localparam int SIDE_SHIFT = 12;
   localparam int MARG_SHIFT = 26;
   localparam int TPROD_W    = DOT_W + TAN_W + 1;
   localparam int DIST_W     = TPROD_W + 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 60;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CAMERA_POSITION = 3'd0,
      CSR_FRONT_AXIS      = 3'd1,
      CSR_UP_AXIS         = 3'd2,
      CSR_RIGHT_AXIS      = 3'd3,
      CSR_DEPTH_LIMITS    = 3'd4,
      CSR_SIDE_MARGINS    = 3'd5,
      CSR_VIEW_TANGENTS   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      REASON_NONE       = 2'd0,
      REASON_DEPTH      = 2'd1,
      REASON_VERTICAL   = 2'd2,
      REASON_HORIZONTAL = 2'd3
   } reason_type;

   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [AXIS_W-1:0]  axis_coef_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [TPROD_W-1:0] tprod_type;
   typedef logic signed [DIST_W-1:0]  dist_type;

   typedef struct packed {
      pos_type z;
      pos_type y;
      pos_type x;
   } camera_type;

   typedef struct packed {
      axis_coef_type z;
      axis_coef_type y;
      axis_coef_type x;
   } axis_type;

   typedef struct packed {
      logic signed [LIM_W-1:0] far_lim;
      logic signed [LIM_W-1:0] near_lim;
   } limits_type;

   typedef struct packed {
      logic [MARGIN_W-1:0] horz;
      logic [MARGIN_W-1:0] vert;
   } margins_type;

   typedef struct packed {
      logic [TAN_W-1:0] horz;
      logic [TAN_W-1:0] vert;
   } tangents_type;

   typedef struct packed {
      camera_type   camera;
      axis_type     front;
      axis_type     up;
      axis_type     right;
      limits_type   limits;
      margins_type  margins;
      tangents_type tangents;
   } cfg_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      pos_type          cz;
      pos_type          cy;
      pos_type          cx;
   } req_item_type;

   typedef struct packed {
      delta_type z;
      delta_type y;
      delta_type x;
   } delta_vec_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      delta_vec_type    d;
   } delta_item_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      dot_type          sz;
      dot_type          sy;
      dot_type          sx;
   } dots_item_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      reason_type       reason;
   } result_type;

endpackage

>>> rtl/sfc_delta.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull offset stage
// Registers the center minus the camera position for each item.
// ----------------------------------------------------------------------------
module sfc_delta
   import sfc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  req_item_type   up_item,
   input  camera_type     camera,
   output logic           dn_valid,
   input  logic           dn_ready,
   output delta_item_type dn_item
);

   logic           vld_ff;
   delta_item_type item_ff;
   delta_item_type item_in;

   assign up_ready = !vld_ff || dn_ready;

   always_comb begin
      item_in.d.x = DELTA_W'(up_item.cx) - DELTA_W'(camera.x);
      item_in.d.y = DELTA_W'(up_item.cy) - DELTA_W'(camera.y);
      item_in.d.z = DELTA_W'(up_item.cz) - DELTA_W'(camera.z);
      item_in.tag = up_item.tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_item  = item_ff;

endmodule

>>> rtl/sfc_dot.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull projection stages
// Nine registered products, then three registered dot-product sums.
// ----------------------------------------------------------------------------
module sfc_dot
   import sfc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  delta_item_type up_item,
   input  axis_type       front,
   input  axis_type       up,
   input  axis_type       right,
   output logic           dn_valid,
   input  logic           dn_ready,
   output dots_item_type  dn_item
);

   logic             vld_a_ff;
   logic             vld_b_ff;
   logic             ready_a;
   logic             ready_b;
   prod_type         prod_ff [3][3];
   prod_type         prod_in [3][3];
   logic [TAG_W-1:0] tag_a_ff;
   dots_item_type    item_b_ff;
   dots_item_type    item_b_in;
   axis_type         ax [3];
   delta_type        dv [3];
   axis_coef_type    coef [3][3];
   dot_type          dot_sum [3];

   assign ready_b  = !vld_b_ff || dn_ready;
   assign ready_a  = !vld_a_ff || ready_b;
   assign up_ready = ready_a;

   always_comb begin
      ax[0] = front;
      ax[1] = up;
      ax[2] = right;
      dv[0] = up_item.d.x;
      dv[1] = up_item.d.y;
      dv[2] = up_item.d.z;
      for (int a = 0; a < 3; a++) begin
         coef[a][0] = ax[a].x;
         coef[a][1] = ax[a].y;
         coef[a][2] = ax[a].z;
         for (int c = 0; c < 3; c++) begin
            prod_in[a][c] = PROD_W'(dv[c]) * PROD_W'(coef[a][c]);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dot_sum[a] = DOT_W'(prod_ff[a][0]) + DOT_W'(prod_ff[a][1])
                    + DOT_W'(prod_ff[a][2]);
      end
      item_b_in.sz  = dot_sum[0];
      item_b_in.sy  = dot_sum[1];
      item_b_in.sx  = dot_sum[2];
      item_b_in.tag = tag_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            vld_a_ff <= up_valid;
         end
         if (ready_b) begin
            vld_b_ff <= vld_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && up_valid) begin
         prod_ff  <= prod_in;
         tag_a_ff <= up_item.tag;
      end
      if (ready_b && vld_a_ff) begin
         item_b_ff <= item_b_in;
      end
   end

   assign dn_valid = vld_b_ff;
   assign dn_item  = item_b_ff;

endmodule

>>> rtl/sfc_test.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull test stages
// Depth range check and cone-tangent products, then the side checks.
// ----------------------------------------------------------------------------
module sfc_test
   import sfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  dots_item_type up_item,
   input  limits_type    limits,
   input  margins_type   margins,
   input  tangents_type  tangents,
   output logic          dn_valid,
   input  logic          dn_ready,
   output result_type    dn_item
);

   logic                      vld_c_ff;
   logic                      vld_d_ff;
   logic                      ready_c;
   logic                      ready_d;
   logic                      depth_ok_ff;
   logic                      depth_ok_in;
   tprod_type                 tprod_v_ff;
   tprod_type                 tprod_v_in;
   tprod_type                 tprod_h_ff;
   tprod_type                 tprod_h_in;
   dot_type                   sy_ff;
   dot_type                   sx_ff;
   logic [TAG_W-1:0]          tag_c_ff;
   result_type                res_ff;
   result_type                res_in;
   logic signed [LIM_W+LIM_SHIFT-1:0] lo_bound;
   logic signed [LIM_W+LIM_SHIFT-1:0] hi_bound;
   dist_type                  dist_v;
   dist_type                  dist_h;
   dist_type                  side_y;
   dist_type                  side_x;
   logic                      vert_ok;
   logic                      horz_ok;

   assign ready_d  = !vld_d_ff || dn_ready;
   assign ready_c  = !vld_c_ff || ready_d;
   assign up_ready = ready_c;

   always_comb begin
      lo_bound    = $signed({limits.near_lim, {LIM_SHIFT{1'b0}}});
      hi_bound    = $signed({limits.far_lim, {LIM_SHIFT{1'b0}}});
      depth_ok_in = (DOT_W'(lo_bound) <= up_item.sz) && (up_item.sz <= DOT_W'(hi_bound));
      tprod_v_in  = TPROD_W'(up_item.sz) * TPROD_W'($signed({1'b0, tangents.vert}));
      tprod_h_in  = TPROD_W'(up_item.sz) * TPROD_W'($signed({1'b0, tangents.horz}));
   end

   always_comb begin
      dist_v  = DIST_W'(tprod_v_ff)
              + DIST_W'($signed({1'b0, margins.vert, {MARG_SHIFT{1'b0}}}));
      dist_h  = DIST_W'(tprod_h_ff)
              + DIST_W'($signed({1'b0, margins.horz, {MARG_SHIFT{1'b0}}}));
      side_y  = DIST_W'($signed({sy_ff, {SIDE_SHIFT{1'b0}}}));
      side_x  = DIST_W'($signed({sx_ff, {SIDE_SHIFT{1'b0}}}));
      vert_ok = (-dist_v <= side_y) && (side_y <= dist_v);
      horz_ok = (-dist_h <= side_x) && (side_x <= dist_h);
      res_in.tag = tag_c_ff;
      if (!depth_ok_ff) begin
         res_in.reason = REASON_DEPTH;
      end else if (!vert_ok) begin
         res_in.reason = REASON_VERTICAL;
      end else if (!horz_ok) begin
         res_in.reason = REASON_HORIZONTAL;
      end else begin
         res_in.reason = REASON_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
      end else begin
         if (ready_c) begin
            vld_c_ff <= up_valid;
         end
         if (ready_d) begin
            vld_d_ff <= vld_c_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c && up_valid) begin
         depth_ok_ff <= depth_ok_in;
         tprod_v_ff  <= tprod_v_in;
         tprod_h_ff  <= tprod_h_in;
         sy_ff       <= up_item.sy;
         sx_ff       <= up_item.sx;
         tag_c_ff    <= up_item.tag;
      end
      if (ready_d && vld_c_ff) begin
         res_ff <= res_in;
      end
   end

   assign dn_valid = vld_d_ff;
   assign dn_item  = res_ff;

endmodule

>>> rtl/sphere_frustum_cull.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull
// Tests a chunk's bounding sphere against the view frustum, one per cycle unless stalled.
// ----------------------------------------------------------------------------
//  Channel  Ports                        Direction  Payload
//  req      req_tvalid/tready/tdata      in         center x, y, z, chunk tag
//  rsp      rsp_tvalid/tready/tdata      out        visible, cull reason, tag
//  csr      csr_we/addr/wdata            in         configuration write
//
//  One item per cycle enters while the result side keeps accepting; a request
//  passes the offset stage, the product and sum stages of the projection and
//  the two test stages before its result reaches the rsp channel.
//  Reset is synchronous and clears the pipeline valid bits and the configuration
//  registers; the data registers are not reset.
//  Each stage holds its item while the one after it is full; bubbles close up.
// ----------------------------------------------------------------------------
module sphere_frustum_cull
   import sfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center_x [19:0], center_y [39:20], center_z [59:40], chunk_tag [75:60]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // visible [0], cull_reason [2:1], tag_out [18:3]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   req_item_type   req_item;
   logic           delta_valid;
   logic           delta_ready;
   delta_item_type delta_item;
   logic           dots_valid;
   logic           dots_ready;
   dots_item_type  dots_item;
   result_type     result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_CAMERA_POSITION: cfg_in.camera   = camera_type'(csr_wdata[59:0]);
            CSR_FRONT_AXIS:      cfg_in.front    = axis_type'(csr_wdata[47:0]);
            CSR_UP_AXIS:         cfg_in.up       = axis_type'(csr_wdata[47:0]);
            CSR_RIGHT_AXIS:      cfg_in.right    = axis_type'(csr_wdata[47:0]);
            CSR_DEPTH_LIMITS:    cfg_in.limits   = limits_type'(csr_wdata[47:0]);
            CSR_SIDE_MARGINS:    cfg_in.margins  = margins_type'(csr_wdata[47:0]);
            CSR_VIEW_TANGENTS:   cfg_in.tangents = tangents_type'(csr_wdata[31:0]);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item = req_item_type'(req_tdata[75:0]);

   sfc_delta u_delta (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_item  (req_item),
      .camera   (cfg_ff.camera),
      .dn_valid (delta_valid),
      .dn_ready (delta_ready),
      .dn_item  (delta_item)
   );

   sfc_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .up_valid (delta_valid),
      .up_ready (delta_ready),
      .up_item  (delta_item),
      .front    (cfg_ff.front),
      .up       (cfg_ff.up),
      .right    (cfg_ff.right),
      .dn_valid (dots_valid),
      .dn_ready (dots_ready),
      .dn_item  (dots_item)
   );

   sfc_test u_test (
      .clock    (clock),
      .reset    (reset),
      .up_valid (dots_valid),
      .up_ready (dots_ready),
      .up_item  (dots_item),
      .limits   (cfg_ff.limits),
      .margins  (cfg_ff.margins),
      .tangents (cfg_ff.tangents),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_item  (result)
   );

   assign rsp_tdata = {5'b0, result.tag, result.reason, result.reason == REASON_NONE};

endmodule

>>> rtl/sfc_checker.sv
// ----------------------------------------------------------------------------
// Sphere frustum cull port checker
// Checks on the result channel as seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "sphere_frustum_cull_defines.svh"

module sfc_checker
   import sfc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `SFC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SFC_ASSERT_SAME(a_visible_reason, rsp_tvalid, rsp_tdata[0] == (rsp_tdata[2:1] == REASON_NONE))
   `SFC_ASSERT_SAME(a_pad_zero, rsp_tvalid, rsp_tdata[23:19] == 5'd0)
   `SFC_ASSERT_RESET(a_reset_empty, !rsp_tvalid)

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere frustum cull testbench
// Streams chunk centers through the culling block under random backpressure
// and checks each result against a cycle-free predictor or a listed verdict.
// A short table of hand-picked chunks, partly on reset values, comes first, then
// several camera setups (extremes, noise, plausible views) with random chunks.
// ----------------------------------------------------------------------------
module tb_top;
   import sfc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_NO_REGISTER = 3'd7;
   localparam int RESET_PROBES     = 6;
   localparam int NUM_PROBES       = 19;
   localparam int ITEMS_PER_SETUP  = 118;
   localparam int PIPE_SLACK       = 12;
   localparam int HOLD_AT          = 250;
   localparam int HOLD_CYCLES      = 200;
   localparam int IDLE_RUN         = 40;

   typedef struct packed {
      logic             visible;
      reason_type       reason;
      logic [TAG_W-1:0] tag;
   } cull_verdict_type;

   typedef struct {
      pos_type          cx;
      pos_type          cy;
      pos_type          cz;
      logic [TAG_W-1:0] tag;
      logic             typed;
      reason_type       want;
   } probe_row_type;

   typedef enum {
      SETUP_PLAUSIBLE,
      SETUP_TOP,
      SETUP_BOTTOM,
      SETUP_ONES,
      SETUP_NOISE
   } setup_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic       row_typed;
   reason_type row_want;
   bit         req_idle = 1'b1;
   bit         rsp_idle = 1'b1;
   int         mismatches = 0;

   camera_type   cam_cfg   = '0;
   axis_type     front_cfg = '0;
   axis_type     up_cfg    = '0;
   axis_type     right_cfg = '0;
   limits_type   lim_cfg   = '0;
   margins_type  marg_cfg  = '0;
   tangents_type tan_cfg   = '0;

   cull_verdict_type chunk_verdicts [$];

   probe_row_type probe_rows [NUM_PROBES] = '{
      '{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF, 1'b1, REASON_NONE},
      '{20'sh80000, 20'sh80000, 20'sh80000, 16'h0000, 1'b1, REASON_NONE},
      '{20'sd0, 20'sd0, 20'sd0, 16'h1234, 1'b1, REASON_NONE},
      '{20'sh7FFFF, 20'sh80000, 20'sd0, 16'h5A5A, 1'b1, REASON_NONE},
      '{20'sh80000, 20'sd0, 20'sh7FFFF, 16'hA5A5, 1'b1, REASON_NONE},
      '{-20'sd1, -20'sd1, -20'sd1, 16'h8000, 1'b1, REASON_NONE},
      '{20'sd0, 20'sd0, 20'sd2560, 16'h0100, 1'b1, REASON_NONE},
      '{20'sd0, 20'sd0, -20'sd30000, 16'h0101, 1'b1, REASON_DEPTH},
      '{20'sd0, 20'sd0, 20'sd30000, 16'h0102, 1'b1, REASON_DEPTH},
      '{20'sd0, 20'sd0, 20'sd25600, 16'h0103, 1'b0, REASON_NONE},
      '{20'sd0, 20'sd0, -20'sd25600, 16'h0104, 1'b0, REASON_NONE},
      '{20'sd0, 20'sd2816, 20'sd2560, 16'h0105, 1'b0, REASON_NONE},
      '{20'sd0, 20'sd2817, 20'sd2560, 16'h0106, 1'b0, REASON_NONE},
      '{20'sd0, -20'sd2817, 20'sd2560, 16'h0107, 1'b0, REASON_NONE},
      '{20'sd2817, 20'sd0, 20'sd2560, 16'h0108, 1'b0, REASON_NONE},
      '{-20'sd2816, 20'sd0, 20'sd2560, 16'h0109, 1'b0, REASON_NONE},
      '{20'sd3000, 20'sd3000, 20'sd2560, 16'h010A, 1'b0, REASON_NONE},
      '{20'sd0, 20'sd0, -20'sd1000, 16'h010B, 1'b0, REASON_NONE},
      '{20'sd0, 20'sd0, 20'sd0, 16'h010C, 1'b0, REASON_NONE}
   };

   sphere_frustum_cull u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint axis_dot(longint dx, longint dy, longint dz, axis_type a);
      return dx * longint'($signed(a.x)) + dy * longint'($signed(a.y))
           + dz * longint'($signed(a.z));
   endfunction

   // Depth is checked first, then the top/bottom planes, then left/right.
   function automatic cull_verdict_type frustum_verdict(req_item_type c);
      longint dx, dy, dz, sz, lo, hi, side, bound;
      cull_verdict_type v;
      dx = longint'($signed(c.cx)) - longint'($signed(cam_cfg.x));
      dy = longint'($signed(c.cy)) - longint'($signed(cam_cfg.y));
      dz = longint'($signed(c.cz)) - longint'($signed(cam_cfg.z));
      sz = axis_dot(dx, dy, dz, front_cfg);
      lo = longint'($signed(lim_cfg.near_lim)) <<< LIM_SHIFT;
      hi = longint'($signed(lim_cfg.far_lim)) <<< LIM_SHIFT;
      v.reason = REASON_NONE;
      if (sz < lo || sz > hi) begin
         v.reason = REASON_DEPTH;
      end else begin
         side  = axis_dot(dx, dy, dz, up_cfg) <<< SIDE_SHIFT;
         bound = (longint'(marg_cfg.vert) << MARG_SHIFT) + sz * longint'(tan_cfg.vert);
         if (side < -bound || side > bound) begin
            v.reason = REASON_VERTICAL;
         end else begin
            side  = axis_dot(dx, dy, dz, right_cfg) <<< SIDE_SHIFT;
            bound = (longint'(marg_cfg.horz) << MARG_SHIFT) + sz * longint'(tan_cfg.horz);
            if (side < -bound || side > bound) v.reason = REASON_HORIZONTAL;
         end
      end
      v.visible = (v.reason == REASON_NONE);
      v.tag     = c.tag;
      return v;
   endfunction

   always @(posedge clock) begin : scoreboard
      req_item_type     item;
      cull_verdict_type seen;
      cull_verdict_type owed;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.visible = rsp_tdata[0];
            seen.reason  = reason_type'(rsp_tdata[2:1]);
            seen.tag     = rsp_tdata[18:3];
            if (chunk_verdicts.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $realtime,
                        rsp_tdata);
               mismatches++;
            end else begin
               owed = chunk_verdicts.pop_front();
               if (seen.visible !== owed.visible) begin
                  $display("%0t: visible, expected %0d, actual %0d", $realtime,
                           owed.visible, seen.visible);
                  mismatches++;
               end
               if (seen.reason !== owed.reason) begin
                  $display("%0t: cull_reason, expected %0d, actual %0d", $realtime,
                           owed.reason, seen.reason);
                  mismatches++;
               end
               if (seen.tag !== owed.tag) begin
                  $display("%0t: tag_out, expected %h, actual %h", $realtime,
                           owed.tag, seen.tag);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            item = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
            if (row_typed) begin
               owed.visible = (row_want == REASON_NONE);
               owed.reason  = row_want;
               owed.tag     = item.tag;
               chunk_verdicts.push_back(owed);
            end else begin
               chunk_verdicts.push_back(frustum_verdict(item));
            end
         end
      end
   end

   // The receiver counts its own transfers and, once, holds off for a long
   // stretch so that the pipeline fills and stalls the request side.
   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      rsp_tready <= 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 11) : 0;
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (taken % IDLE_RUN == 0) rsp_idle = ($urandom_range(0, 3) != 0);
         @(negedge clock);
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      logic [63:0]           junk;
      logic [CSR_DATA_W-1:0] keep;
      logic [CSR_DATA_W-1:0] data;
      int                    w;
      junk = {$urandom, $urandom};
      case (addr)
         CSR_CAMERA_POSITION: w = 60;
         CSR_VIEW_TANGENTS:   w = 32;
         CSR_NO_REGISTER:     w = 0;
         default:             w = 48;
      endcase
      keep = (w == 60) ? '1 : ((60'd1 << w) - 60'd1);
      data = (value & keep) | (junk[CSR_DATA_W-1:0] & ~keep);
      case (addr)
         CSR_CAMERA_POSITION: cam_cfg   = data[59:0];
         CSR_FRONT_AXIS:      front_cfg = data[47:0];
         CSR_UP_AXIS:         up_cfg    = data[47:0];
         CSR_RIGHT_AXIS:      right_cfg = data[47:0];
         CSR_DEPTH_LIMITS:    lim_cfg   = data[47:0];
         CSR_SIDE_MARGINS:    marg_cfg  = data[47:0];
         CSR_VIEW_TANGENTS:   tan_cfg   = data[31:0];
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic offer_chunk(req_item_type item, logic typed, reason_type want);
      int gap;
      gap = req_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(item);
      row_typed  <= typed;
      row_want   <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(0, IDLE_RUN - 1) == 0) req_idle = ($urandom_range(0, 3) != 0);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (chunk_verdicts.size() > 0) @(negedge clock);
      repeat (PIPE_SLACK) @(negedge clock);
   endtask

   function automatic axis_type plausible_axis(int dir);
      axis_type a;
      a.x = AXIS_W'($urandom_range(0, 4000) - 2000);
      a.y = AXIS_W'($urandom_range(0, 4000) - 2000);
      a.z = AXIS_W'($urandom_range(0, 4000) - 2000);
      case (dir)
         0:       a.x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         1:       a.y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: a.z = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      endcase
      return a;
   endfunction

   task automatic load_setup(setup_kind_type kind);
      camera_type   cam;
      axis_type     f, u, r;
      limits_type   lim;
      margins_type  m;
      tangents_type t;
      logic [63:0]  noise [7];
      int           fa;
      for (int i = 0; i < 7; i++) noise[i] = {$urandom, $urandom};
      case (kind)
         SETUP_TOP: begin
            cam = {3{20'h7FFFF}};
            f   = {3{16'h7FFF}};
            u   = f;
            r   = f;
            lim = {24'h7FFFFF, 24'h7FFFFF};
            m   = '1;
            t   = '1;
         end
         SETUP_BOTTOM: begin
            cam = {3{20'h80000}};
            f   = {3{16'h8000}};
            u   = f;
            r   = f;
            lim = {24'h7FFFFF, 24'h800000};
            m   = '0;
            t   = '0;
         end
         SETUP_ONES: begin
            cam = '1;
            f   = '1;
            u   = '1;
            r   = '1;
            lim = '1;
            m   = '1;
            t   = '1;
         end
         SETUP_NOISE: begin
            cam = noise[0][59:0];
            f   = noise[1][47:0];
            u   = noise[2][47:0];
            r   = noise[3][47:0];
            lim = noise[4][47:0];
            m   = noise[5][47:0];
            t   = noise[6][31:0];
         end
         default: begin
            cam          = noise[0][59:0];
            fa           = $urandom_range(0, 2);
            f            = plausible_axis(fa);
            u            = plausible_axis((fa + 1) % 3);
            r            = plausible_axis((fa + 2) % 3);
            lim.near_lim = LIM_W'($urandom_range(0, 2000) - 1000);
            lim.far_lim  = LIM_W'($urandom_range(1000, 40000));
            m.vert       = MARGIN_W'($urandom_range(0, 3000));
            m.horz       = MARGIN_W'($urandom_range(0, 3000));
            t.vert       = TAN_W'($urandom_range(1000, 12000));
            t.horz       = TAN_W'($urandom_range(1000, 12000));
         end
      endcase
      write_reg(CSR_CAMERA_POSITION, CSR_DATA_W'(cam));
      write_reg(CSR_FRONT_AXIS, CSR_DATA_W'(f));
      write_reg(CSR_UP_AXIS, CSR_DATA_W'(u));
      write_reg(CSR_RIGHT_AXIS, CSR_DATA_W'(r));
      write_reg(CSR_DEPTH_LIMITS, CSR_DATA_W'(lim));
      write_reg(CSR_SIDE_MARGINS, CSR_DATA_W'(m));
      write_reg(CSR_VIEW_TANGENTS, CSR_DATA_W'(t));
      write_reg(CSR_NO_REGISTER, '1);
      csr_we <= 1'b0;
   endtask

   function automatic pos_type random_coord(pos_type base, bit near);
      case ($urandom_range(0, 9))
         0:       return 20'sh7FFFF;
         1:       return 20'sh80000;
         default: begin
            if (near) return POS_W'(int'(base) + $urandom_range(0, 65535) - 32768);
            return POS_W'($urandom);
         end
      endcase
   endfunction

   function automatic req_item_type random_chunk(setup_kind_type kind);
      req_item_type c;
      bit           near;
      near  = (kind == SETUP_PLAUSIBLE) && ($urandom_range(0, 99) < 85);
      c.cx  = random_coord(cam_cfg.x, near);
      c.cy  = random_coord(cam_cfg.y, near);
      c.cz  = random_coord(cam_cfg.z, near);
      c.tag = TAG_W'($urandom);
      return c;
   endfunction

   initial begin : stimulus
      setup_kind_type plan [8];
      req_item_type   c;
      plan = '{SETUP_PLAUSIBLE, SETUP_TOP, SETUP_PLAUSIBLE, SETUP_BOTTOM,
               SETUP_NOISE, SETUP_PLAUSIBLE, SETUP_ONES, SETUP_PLAUSIBLE};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      row_typed  <= 1'b0;
      row_want   <= REASON_NONE;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_CAMERA_POSITION;
      csr_wdata  <= '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_PROBES; i++) begin
         if (i == RESET_PROBES) begin
            // Camera at the origin looking down +z, one-unit margins, 45 degree
            // half angles and a depth window of -100 to +100.
            drain_pipeline();
            write_reg(CSR_CAMERA_POSITION, '0);
            write_reg(CSR_FRONT_AXIS, 60'h0_4000_0000_0000);
            write_reg(CSR_UP_AXIS, 60'h0_0000_4000_0000);
            write_reg(CSR_RIGHT_AXIS, 60'h0_0000_0000_4000);
            write_reg(CSR_DEPTH_LIMITS, 60'h006400_FF9C00);
            write_reg(CSR_SIDE_MARGINS, 60'h000100_000100);
            write_reg(CSR_VIEW_TANGENTS, 60'h1000_1000);
            write_reg(CSR_NO_REGISTER, '1);
            csr_we <= 1'b0;
         end
         c.cx  = probe_rows[i].cx;
         c.cy  = probe_rows[i].cy;
         c.cz  = probe_rows[i].cz;
         c.tag = probe_rows[i].tag;
         offer_chunk(c, probe_rows[i].typed, probe_rows[i].want);
      end

      foreach (plan[p]) begin
         drain_pipeline();
         load_setup(plan[p]);
         repeat (ITEMS_PER_SETUP) offer_chunk(random_chunk(plan[p]), 1'b0, REASON_NONE);
      end

      drain_pipeline();
      if (mismatches == 0 && chunk_verdicts.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
